/* design/szp_pkg.sv */
// Shared types, codes and helper functions of the size string parser.
package szp_pkg;

  // Parse phase codes.
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_PLUS   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_TRAIL  = 3'd3;
  localparam logic [2:0] PH_UNIT2  = 3'd4;
  localparam logic [2:0] PH_SKIP   = 3'd5;
  localparam logic [2:0] PH_EMPTY  = 3'd6;

  // Unit codes.
  localparam logic [1:0] UNIT_MB = 2'd0;
  localparam logic [1:0] UNIT_GB = 2'd1;
  localparam logic [1:0] UNIT_B  = 2'd2;

  // Scaling shifts.
  localparam int unsigned MB_SHIFT = 20;
  localparam int unsigned GB_SHIFT = 30;

  localparam logic [63:0] MAX_TIMES_TEN = 64'h1999_9999_9999_9999;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_M     = 8'h6D;

  // Parser state carried from one character to the next.
  typedef struct packed {
    logic [2:0]  phase;
    logic [63:0] count;
    logic [7:0]  unit_char;
    logic [1:0]  unit;
    logic        ovf;
  } szp_state_t;

  localparam szp_state_t STATE_RESET = '{
    phase:     PH_LEAD,
    count:     64'd0,
    unit_char: 8'd0,
    unit:      UNIT_MB,
    ovf:       1'b0
  };

  // Lower-case only the letters A to Z.
  function automatic logic [7:0] lower_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Unit from the first two lower-cased characters after the count.
  function automatic logic [1:0] judge_unit(input logic [7:0] c1, input logic [7:0] c2);
    logic [1:0] u;
    if (c1 == CH_G && c2 == CH_B) begin
      u = UNIT_GB;
    end else if (c1 == CH_M && c2 == CH_B) begin
      u = UNIT_MB;
    end else if (c1 == CH_B) begin
      u = UNIT_B;
    end else if (c1 == CH_G && c2 == CH_NUL) begin
      u = UNIT_GB;
    end else begin
      u = UNIT_MB;
    end
    return u;
  endfunction

endpackage

/* design/szp_step.sv */
// Next-state and result logic for one character of the size string.
module szp_step (
  input  logic [7:0]          char_code_i,
  input  szp_pkg::szp_state_t cur_i,
  output szp_pkg::szp_state_t nxt_o,
  output logic                done_o,
  output logic [63:0]         size_bytes_o,
  output logic                overflowed_o
);

  logic [63:0] prod;
  logic [64:0] sum;
  logic        dig_ovf;
  logic [7:0]  low_c;
  logic [1:0]  end_unit;
  logic        counted;

  // Count times ten plus the digit, with carry out for wrap detection.
  assign prod    = {cur_i.count[60:0], 3'b000} + {cur_i.count[62:0], 1'b0};
  assign sum     = {1'b0, prod} + {61'd0, char_code_i[3:0]};
  assign dig_ovf = (cur_i.count > szp_pkg::MAX_TIMES_TEN) || sum[64];
  assign low_c   = szp_pkg::lower_char(char_code_i);
  assign done_o  = (char_code_i == szp_pkg::CH_NUL);

  // Final unit and scaling when the string ends.
  always_comb begin
    counted  = 1'b0;
    end_unit = szp_pkg::UNIT_MB;
    case (cur_i.phase)
      szp_pkg::PH_DIGITS, szp_pkg::PH_TRAIL: begin
        counted = 1'b1;
      end
      szp_pkg::PH_UNIT2: begin
        counted  = 1'b1;
        end_unit = szp_pkg::judge_unit(cur_i.unit_char, szp_pkg::CH_NUL);
      end
      szp_pkg::PH_SKIP: begin
        counted  = 1'b1;
        end_unit = cur_i.unit;
      end
      default: begin
        counted = 1'b0;
      end
    endcase

    size_bytes_o = 64'd0;
    overflowed_o = 1'b0;
    if (counted) begin
      overflowed_o = cur_i.ovf;
      case (end_unit)
        szp_pkg::UNIT_GB: begin
          if (cur_i.count[63:64-szp_pkg::GB_SHIFT] != '0) overflowed_o = 1'b1;
          size_bytes_o = cur_i.count << szp_pkg::GB_SHIFT;
        end
        szp_pkg::UNIT_B: begin
          size_bytes_o = cur_i.count;
        end
        default: begin
          if (cur_i.count[63:64-szp_pkg::MB_SHIFT] != '0) overflowed_o = 1'b1;
          size_bytes_o = cur_i.count << szp_pkg::MB_SHIFT;
        end
      endcase
    end
  end

  // Phase transitions for a nonzero character; the end of string restarts.
  always_comb begin
    nxt_o = cur_i;
    if (done_o) begin
      nxt_o = szp_pkg::STATE_RESET;
    end else begin
      case (cur_i.phase)
        szp_pkg::PH_LEAD: begin
          if (szp_pkg::is_blank(char_code_i)) begin
            nxt_o.phase = szp_pkg::PH_LEAD;
          end else if (char_code_i == szp_pkg::CH_PLUS) begin
            nxt_o.phase = szp_pkg::PH_PLUS;
          end else if (szp_pkg::is_digit(char_code_i)) begin
            nxt_o.count = sum[63:0];
            nxt_o.ovf   = cur_i.ovf | dig_ovf;
            nxt_o.phase = szp_pkg::PH_DIGITS;
          end else begin
            nxt_o.phase = szp_pkg::PH_EMPTY;
          end
        end
        szp_pkg::PH_PLUS: begin
          if (szp_pkg::is_digit(char_code_i)) begin
            nxt_o.count = sum[63:0];
            nxt_o.ovf   = cur_i.ovf | dig_ovf;
            nxt_o.phase = szp_pkg::PH_DIGITS;
          end else begin
            nxt_o.phase = szp_pkg::PH_EMPTY;
          end
        end
        szp_pkg::PH_DIGITS: begin
          if (szp_pkg::is_digit(char_code_i)) begin
            nxt_o.count = sum[63:0];
            nxt_o.ovf   = cur_i.ovf | dig_ovf;
          end else if (szp_pkg::is_blank(char_code_i)) begin
            nxt_o.phase = szp_pkg::PH_TRAIL;
          end else begin
            nxt_o.unit_char = low_c;
            nxt_o.phase     = szp_pkg::PH_UNIT2;
          end
        end
        szp_pkg::PH_TRAIL: begin
          if (!szp_pkg::is_blank(char_code_i)) begin
            nxt_o.unit_char = low_c;
            nxt_o.phase     = szp_pkg::PH_UNIT2;
          end
        end
        szp_pkg::PH_UNIT2: begin
          nxt_o.unit  = szp_pkg::judge_unit(cur_i.unit_char, low_c);
          nxt_o.phase = szp_pkg::PH_SKIP;
        end
        szp_pkg::PH_SKIP: begin
          nxt_o.phase = szp_pkg::PH_SKIP;
        end
        default: begin
          nxt_o.phase = szp_pkg::PH_EMPTY;
        end
      endcase
    end
  end

endmodule

/* design/size_with_unit_parser.sv */
// Top level of the size string parser: handshake, parser state and result register.
//
// The block takes one character per transaction and accepts a new one in every cycle
// in which input is not held off. Each character updates the parser state in the
// cycle it is accepted; the state update is a times-ten multiply-add on the 64-bit count.
// A zero character ends the string: in the cycle after it is accepted, the size in bytes
// and the overflow flag appear in the result register, and the parser starts over for
// the next string. Input is held off only while a result waits and the output side
// is stalled.
module size_with_unit_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] size_bytes_o,
  output logic        overflowed_o
);

  szp_pkg::szp_state_t state_q, state_d;
  logic        done;
  logic [63:0] size_d;
  logic        ovf_d;
  logic        out_valid_q;
  logic [63:0] size_q;
  logic        ovf_q;
  logic        in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Per-character parsing logic.
  szp_step u_step (
    .char_code_i  (char_code_i),
    .cur_i        (state_q),
    .nxt_o        (state_d),
    .done_o       (done),
    .size_bytes_o (size_d),
    .overflowed_o (ovf_d)
  );

  // Parser state advances on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= szp_pkg::STATE_RESET;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire && done) begin
      size_q <= size_d;
      ovf_q  <= ovf_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign size_bytes_o = size_q;
  assign overflowed_o = ovf_q;

endmodule

/* tb/tb.sv */
// Self-checking testbench of the size string parser, with scoreboard, drivers and stimulus.
`timescale 1ns / 1ps

module tb;

  // One expected or observed parse result.
  typedef struct packed {
    logic [63:0] bytes_total;
    logic        ovf_flag;
  } size_result_t;

  // Tracks the parser state of its own and holds the sizes still owed by the block.
  class size_scoreboard;
    logic [2:0]   phase;
    logic [63:0]  count;
    logic [7:0]   unit_c1;
    logic [1:0]   unit;
    logic         ovf;
    size_result_t pending[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  overflows;
    int unsigned  bytes_units;
    int unsigned  gb_units;

    function new();
      errors      = 0;
      checked     = 0;
      overflows   = 0;
      bytes_units = 0;
      gb_units    = 0;
      restart();
    endfunction

    function void restart();
      phase   = szp_pkg::PH_LEAD;
      count   = 64'd0;
      unit_c1 = 8'd0;
      unit    = szp_pkg::UNIT_MB;
      ovf     = 1'b0;
    endfunction

    function logic [7:0] fold_case(logic [7:0] c);
      if (c >= szp_pkg::CH_UP_A && c <= szp_pkg::CH_UP_Z) begin
        return c + 8'd32;
      end
      return c;
    endfunction

    function logic blank_char(logic [7:0] c);
      return c == szp_pkg::CH_SPACE || c == szp_pkg::CH_TAB;
    endfunction

    function logic digit_char(logic [7:0] c);
      return c >= szp_pkg::CH_ZERO && c <= szp_pkg::CH_NINE;
    endfunction

    // Unit from the first two lower-cased characters after the count.
    function logic [1:0] unit_from(logic [7:0] c1, logic [7:0] c2);
      if (c1 == szp_pkg::CH_G && c2 == szp_pkg::CH_B) return szp_pkg::UNIT_GB;
      if (c1 == szp_pkg::CH_M && c2 == szp_pkg::CH_B) return szp_pkg::UNIT_MB;
      if (c1 == szp_pkg::CH_B) return szp_pkg::UNIT_B;
      if (c1 == szp_pkg::CH_G && c2 == szp_pkg::CH_NUL) return szp_pkg::UNIT_GB;
      return szp_pkg::UNIT_MB;
    endfunction

    // Times ten plus the digit, flagging any carry out of 64 bits.
    function void accumulate(logic [7:0] c);
      logic [63:0] prod;
      logic [63:0] sum;
      prod = count * 64'd10;
      sum  = prod + {56'd0, c - szp_pkg::CH_ZERO};
      if (count > szp_pkg::MAX_TIMES_TEN || sum < prod) begin
        ovf = 1'b1;
      end
      count = sum;
    endfunction

    // A terminating character yields the scaled size; others only move the state.
    function void note_char(logic [7:0] c);
      size_result_t res;
      logic [1:0]   u;
      if (c == szp_pkg::CH_NUL) begin
        res = '0;
        if (phase == szp_pkg::PH_DIGITS || phase == szp_pkg::PH_TRAIL ||
            phase == szp_pkg::PH_UNIT2 || phase == szp_pkg::PH_SKIP) begin
          u = szp_pkg::UNIT_MB;
          if (phase == szp_pkg::PH_UNIT2) begin
            u = unit_from(unit_c1, szp_pkg::CH_NUL);
          end else if (phase == szp_pkg::PH_SKIP) begin
            u = unit;
          end
          res.ovf_flag = ovf;
          if (u == szp_pkg::UNIT_GB) begin
            gb_units++;
            if ((count >> (64 - szp_pkg::GB_SHIFT)) != 0) res.ovf_flag = 1'b1;
            res.bytes_total = count << szp_pkg::GB_SHIFT;
          end else if (u == szp_pkg::UNIT_B) begin
            bytes_units++;
            res.bytes_total = count;
          end else begin
            if ((count >> (64 - szp_pkg::MB_SHIFT)) != 0) res.ovf_flag = 1'b1;
            res.bytes_total = count << szp_pkg::MB_SHIFT;
          end
        end
        if (res.ovf_flag) overflows++;
        pending.push_back(res);
        restart();
        return;
      end
      case (phase)
        szp_pkg::PH_LEAD: begin
          if (blank_char(c)) begin
          end else if (c == szp_pkg::CH_PLUS) begin
            phase = szp_pkg::PH_PLUS;
          end else if (digit_char(c)) begin
            accumulate(c);
            phase = szp_pkg::PH_DIGITS;
          end else begin
            phase = szp_pkg::PH_EMPTY;
          end
        end
        szp_pkg::PH_PLUS: begin
          if (digit_char(c)) begin
            accumulate(c);
            phase = szp_pkg::PH_DIGITS;
          end else begin
            phase = szp_pkg::PH_EMPTY;
          end
        end
        szp_pkg::PH_DIGITS: begin
          if (digit_char(c)) begin
            accumulate(c);
          end else if (blank_char(c)) begin
            phase = szp_pkg::PH_TRAIL;
          end else begin
            unit_c1 = fold_case(c);
            phase   = szp_pkg::PH_UNIT2;
          end
        end
        szp_pkg::PH_TRAIL: begin
          if (!blank_char(c)) begin
            unit_c1 = fold_case(c);
            phase   = szp_pkg::PH_UNIT2;
          end
        end
        szp_pkg::PH_UNIT2: begin
          unit  = unit_from(unit_c1, fold_case(c));
          phase = szp_pkg::PH_SKIP;
        end
        szp_pkg::PH_SKIP: begin
        end
        default: begin
          phase = szp_pkg::PH_EMPTY;
        end
      endcase
    endfunction

    function void check_result(logic [63:0] bytes_total, logic ovf_flag);
      size_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: unexpected result size %h ovf %b", bytes_total, ovf_flag);
        end
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.bytes_total !== bytes_total || want.ovf_flag !== ovf_flag) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: mismatch: expected size %h ovf %b, got size %h ovf %b",
                   want.bytes_total, want.ovf_flag, bytes_total, ovf_flag);
        end
      end
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i  = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [63:0] size_bytes_o;
  logic        overflowed_o;

  size_scoreboard sb;
  int unsigned    idle_pct   = 0;
  int unsigned    stall_pct  = 0;
  int unsigned    chars_sent = 0;
  int unsigned    strings    = 0;
  logic [7:0]     text[$];

  string unit_words[14] = '{"", "b", "B", "g", "G", "gb", "GB", "Gb", "m", "M", "mb", "MB",
                            "kb", "gx"};
  string edge_counts[11] = '{"18446744073709551615", "18446744073709551616",
                             "1844674407370955161", "1844674407370955162",
                             "17592186044415", "17592186044416", "17179869183",
                             "17179869184", "000000000000000000000000042",
                             "99999999999999999999999", "0"};

  size_with_unit_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .size_bytes_o (size_bytes_o),
    .overflowed_o (overflowed_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver side: random stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Watch both channels; results are checked before the same edge's input is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(size_bytes_o, overflowed_o);
      if (in_valid_i && in_ready_o) sb.note_char(char_code_i);
    end
  end

  // Offer one character, with random idle cycles first, and wait for its transaction.
  task automatic send_char(input logic [7:0] c);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic end_string();
    send_char(szp_pkg::CH_NUL);
    strings++;
  endtask

  // Hold the sender off until every owed result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(255, 1));
  endfunction

  function automatic logic [7:0] blank();
    return $urandom_range(1) ? szp_pkg::CH_SPACE : szp_pkg::CH_TAB;
  endfunction

  // Mostly well-formed sizes with random content; the rest is noise or broken prefixes.
  function automatic void build_string();
    int unsigned kind;
    int unsigned n;
    text.delete();
    kind = $urandom_range(99);
    if (kind < 70) begin
      n = $urandom_range(3);
      if ($urandom_range(2) != 0) n = 0;
      repeat (n) text.push_back(blank());
      if ($urandom_range(3) == 0) text.push_back(szp_pkg::CH_PLUS);
      if ($urandom_range(7) == 0) begin
        add_text(edge_counts[$urandom_range(10)]);
      end else begin
        n = ($urandom_range(9) == 0) ? $urandom_range(22, 7) : $urandom_range(6, 1);
        repeat (n) text.push_back(szp_pkg::CH_ZERO + 8'($urandom_range(9)));
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) text.push_back(blank());
      end
      if ($urandom_range(5) == 0) begin
        text.push_back(any_char());
        if ($urandom_range(1)) text.push_back(any_char());
      end else begin
        add_text(unit_words[$urandom_range(13)]);
      end
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(3, 1)) text.push_back(any_char());
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(6)) text.push_back(any_char());
    end else begin
      repeat ($urandom_range(2)) text.push_back(blank());
      text.push_back(szp_pkg::CH_PLUS);
      if ($urandom_range(1)) text.push_back(szp_pkg::CH_PLUS);
      repeat ($urandom_range(2)) text.push_back(any_char());
    end
    text.push_back(szp_pkg::CH_NUL);
  endfunction

  // Main sequence: reset, directed strings, then random strings in four phases of idling and stalling.
  initial begin
    int unsigned quota;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty, blanks and plus with a bare gigabyte letter, bytes, mixed-case
    // megabytes, plus without a digit, a high character first, a high unit character.
    end_string();
    send_char(szp_pkg::CH_SPACE);
    send_char(szp_pkg::CH_TAB);
    send_text("+7G");
    end_string();
    send_text("5b");
    end_string();
    send_text("3 mB");
    end_string();
    send_text("+x");
    end_string();
    send_char(8'hFF);
    send_text("9");
    end_string();
    send_text("2");
    send_char(8'h80);
    end_string();
    drain();

    quota = 1650 / 4;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      while (chars_sent < 24 + quota * (p + 1)) begin
        build_string();
        foreach (text[i]) send_char(text[i]);
        strings++;
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("tb: %0d characters in %0d strings, %0d sizes checked", chars_sent, strings,
             sb.checked);
    $display("tb: %0d with overflow, %0d in bytes, %0d in gigabytes", sb.overflows,
             sb.bytes_units, sb.gb_units);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches, %0d sizes never returned", sb.errors, sb.pending.size());
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3000000;
    $display("tb: timeout");
    $display("tb: failure");
    $finish;
  end

endmodule
